### design/tnb_pkg.sv
// ----------------------------------------------------------------------------
// Top-N bucket tracker package
// Shared constants, record codes, controller states and control structs.
// ----------------------------------------------------------------------------
package tnb_pkg;

   // Default parameter values.
   localparam int TOP_DEPTH_DEF   = 8;
   localparam int EVENT_BITS_DEF  = 32;
   localparam int BUCKET_BITS_DEF = 32;

   // Fixed field widths of the channels.
   localparam int FIELD_W  = 32;
   localparam int WIDE_W   = 64;
   localparam int LIMIT_W  = 4;
   localparam int LIMIT_RESET = 8;

   // Control widths that cover the whole TOP_DEPTH range (up to 32).
   localparam int CNT_W    = 6;
   localparam int IDX_W    = 5;
   localparam int REC_W    = 7;

   // Input function codes.
   localparam logic FUNC_VISIT = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   // Bucket kinds.
   localparam logic [1:0] KIND_BRANCH = 2'd0;
   localparam logic [1:0] KIND_LEAF   = 2'd1;

   // Group codes.
   localparam logic GRP_LEAF   = 1'b0;
   localparam logic GRP_BRANCH = 1'b1;

   // Record types.
   localparam logic [1:0] REC_STATS = 2'd0;
   localparam logic [1:0] REC_ENTRY = 2'd1;
   localparam logic [1:0] REC_DROP  = 2'd2;

   // Register index of the limit register.
   localparam logic REG_TOP_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATS,
      ST_ENTRY,
      ST_DROP,
      ST_CLEAR
   } ctl_state_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic             visit;
      logic             clear;
      logic             emit;
      logic [1:0]       rtype;
      logic             grp;
      logic [IDX_W-1:0] idx;
      logic             final_res;
   } dp_cmd_type;

   // Status of one group.
   typedef struct packed {
      logic [CNT_W-1:0] n;
      logic             total_nz;
      logic             drop_nz;
   } grp_status_type;

endpackage

### design/tnb_if.sv
// ----------------------------------------------------------------------------
// Top-N bucket tracker channels
// Valid/ready channel interfaces for request words and response words.
// ----------------------------------------------------------------------------
interface tnb_req_if;
   import tnb_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [1:0]         kind;
   logic [FIELD_W-1:0] bucket;
   logic [FIELD_W-1:0] events;

   modport source (output valid, func, kind, bucket, events, input ready);
   modport sink   (input valid, func, kind, bucket, events, output ready);
endinterface

interface tnb_rsp_if;
   import tnb_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         record_type;
   logic               group;
   logic [FIELD_W-1:0] bucket_id;
   logic [FIELD_W-1:0] event_count;
   logic [WIDE_W-1:0]  tally;
   logic [WIDE_W-1:0]  sum_events;
   logic [FIELD_W-1:0] least;
   logic [FIELD_W-1:0] most;
   logic               final_res;

   modport source (output valid, record_type, group, bucket_id, event_count, tally,
                   sum_events, least, most, final_res, input ready);
   modport sink   (input valid, record_type, group, bucket_id, event_count, tally,
                   sum_events, least, most, final_res, output ready);
endinterface

### design/top_n_bucket_tracker_core.sv
// ----------------------------------------------------------------------------
// Top-N bucket tracker core
// Visit words stream at one word per cycle while the controller is idle; a flush
// holds off new request words until its readout and clear are done, and each
// response word sits in a one-word output register.
// Reset clears every list, statistic and tie record; the limit returns to 8.
// ----------------------------------------------------------------------------
module top_n_bucket_tracker_core #(
   parameter int TOP_DEPTH   = tnb_pkg::TOP_DEPTH_DEF,
   parameter int EVENT_BITS  = tnb_pkg::EVENT_BITS_DEF,
   parameter int BUCKET_BITS = tnb_pkg::BUCKET_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   tnb_req_if.sink      req_ch,
   tnb_rsp_if.source    rsp_ch,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import tnb_pkg::*;

   logic [LIMIT_W-1:0]   top_limit_ff;
   dp_cmd_type           cmd;
   grp_status_type [1:0] status;

   // Limit register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_limit_ff <= LIMIT_W'(LIMIT_RESET);
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_TOP_LIMIT)) begin
         top_limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOP_LIMIT) ? {28'd0, top_limit_ff} : 32'd0;

   tnb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   tnb_datapath #(
      .TOP_DEPTH   (TOP_DEPTH),
      .EVENT_BITS  (EVENT_BITS),
      .BUCKET_BITS (BUCKET_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .limit       (top_limit_ff),
      .kind        (req_ch.kind),
      .bucket      (req_ch.bucket),
      .events      (req_ch.events),
      .cmd         (cmd),
      .status      (status),
      .record_type (rsp_ch.record_type),
      .group       (rsp_ch.group),
      .bucket_id   (rsp_ch.bucket_id),
      .event_count (rsp_ch.event_count),
      .tally       (rsp_ch.tally),
      .sum_events  (rsp_ch.sum_events),
      .least       (rsp_ch.least),
      .most        (rsp_ch.most),
      .final_res   (rsp_ch.final_res)
   );

endmodule

### design/tnb_datapath.sv
// ----------------------------------------------------------------------------
// Top-N bucket tracker datapath
// Sorted lists with compare-and-shift cells, group statistics and the
// response word register.
// ----------------------------------------------------------------------------
module tnb_datapath #(
   parameter int TOP_DEPTH   = tnb_pkg::TOP_DEPTH_DEF,
   parameter int EVENT_BITS  = tnb_pkg::EVENT_BITS_DEF,
   parameter int BUCKET_BITS = tnb_pkg::BUCKET_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tnb_pkg::LIMIT_W-1:0]    limit,
   input  logic [1:0]                     kind,
   input  logic [tnb_pkg::FIELD_W-1:0]    bucket,
   input  logic [tnb_pkg::FIELD_W-1:0]    events,
   input  tnb_pkg::dp_cmd_type            cmd,
   output tnb_pkg::grp_status_type [1:0]  status,
   output logic [1:0]                     record_type,
   output logic                           group,
   output logic [tnb_pkg::FIELD_W-1:0]    bucket_id,
   output logic [tnb_pkg::FIELD_W-1:0]    event_count,
   output logic [tnb_pkg::WIDE_W-1:0]     tally,
   output logic [tnb_pkg::WIDE_W-1:0]     sum_events,
   output logic [tnb_pkg::FIELD_W-1:0]    least,
   output logic [tnb_pkg::FIELD_W-1:0]    most,
   output logic                           final_res
);
   import tnb_pkg::*;

   localparam int NW = $clog2(TOP_DEPTH + 1);
   localparam int IW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;

   // List storage, written before it is read.
   logic [EVENT_BITS-1:0]  cnt_ff [2][TOP_DEPTH];
   logic [BUCKET_BITS-1:0] bkt_ff [2][TOP_DEPTH];

   logic [NW-1:0]         n_ff        [2];
   logic [EVENT_BITS-1:0] tie_val_ff  [2];
   logic [WIDE_W-1:0]     drop_ff     [2];
   logic [EVENT_BITS-1:0] min_ff      [2];
   logic [EVENT_BITS-1:0] max_ff      [2];
   logic [WIDE_W-1:0]     total_ff    [2];
   logic [WIDE_W-1:0]     buckets_ff  [2];

   logic [1:0]         rtype_ff;
   logic               grp_ff;
   logic [FIELD_W-1:0] bid_ff;
   logic [FIELD_W-1:0] evc_ff;
   logic [WIDE_W-1:0]  tally_ff;
   logic [WIDE_W-1:0]  sum_ff;
   logic [FIELD_W-1:0] least_ff;
   logic [FIELD_W-1:0] most_ff;
   logic               final_ff;

   logic                  g;
   logic                  has_stats;
   logic [EVENT_BITS-1:0] ev;
   logic [BUCKET_BITS-1:0] bk;
   logic [NW-1:0]         lim;
   logic [NW-1:0]         n;
   logic [NW-1:0]         n_eff;
   logic                  full;
   logic [EVENT_BITS-1:0] last;
   logic [EVENT_BITS-1:0] prev;
   logic                  do_insert;
   logic [EVENT_BITS-1:0] tie_val_in;
   logic [WIDE_W-1:0]     drop_in;
   logic [TOP_DEPTH-1:0]  gt;
   logic [IW-1:0]         rd_idx;

   assign g         = (kind == KIND_LEAF) ? GRP_LEAF : GRP_BRANCH;
   assign has_stats = (kind == KIND_LEAF) || (kind == KIND_BRANCH);
   assign ev        = EVENT_BITS'(events);
   assign bk        = BUCKET_BITS'(bucket);
   assign n         = n_ff[g];
   assign last      = cnt_ff[g][IW'(n - 1'b1)];
   assign prev      = cnt_ff[g][IW'(n - NW'(2))];
   assign full      = (n >= lim) && (n != '0);
   assign rd_idx    = cmd.idx[IW-1:0];

   // Clamp the limit into one to TOP_DEPTH.
   always_comb begin
      if (limit == '0) begin
         lim = NW'(1);
      end else if (int'(limit) > TOP_DEPTH) begin
         lim = NW'(TOP_DEPTH);
      end else begin
         lim = NW'(limit);
      end
   end

   // Eviction and tie bookkeeping for a full list.
   always_comb begin
      n_eff      = n;
      do_insert  = 1'b1;
      tie_val_in = tie_val_ff[g];
      drop_in    = drop_ff[g];
      if (full) begin
         if (ev < last) begin
            do_insert = 1'b0;
         end else if (ev == last) begin
            do_insert  = 1'b0;
            tie_val_in = ev;
            drop_in    = drop_ff[g] + 64'd1;
         end else begin
            n_eff = n - 1'b1;
            if ((n_eff != '0) && (prev == last)) begin
               if (last > tie_val_ff[g]) begin
                  tie_val_in = last;
                  drop_in    = 64'd1;
               end else begin
                  drop_in = drop_ff[g] + 64'd1;
               end
            end else begin
               tie_val_in = '0;
               drop_in    = '0;
            end
         end
      end
   end

   // Each cell compares its count against the new one.
   always_comb begin
      for (int i = 0; i < TOP_DEPTH; i++) begin
         gt[i] = (NW'(i) < n_eff) && (cnt_ff[g][i] > ev);
      end
   end

   // Compare-and-shift cells: keep, take the new word, or take the neighbor's.
   always_ff @(posedge clock) begin
      if (cmd.visit && do_insert) begin
         for (int i = 0; i < TOP_DEPTH; i++) begin
            if ((NW'(i) <= n_eff) && !gt[i]) begin
               if (i == 0) begin
                  cnt_ff[g][i] <= ev;
                  bkt_ff[g][i] <= bk;
               end else if (gt[(i > 0) ? i - 1 : 0]) begin
                  cnt_ff[g][i] <= ev;
                  bkt_ff[g][i] <= bk;
               end else begin
                  cnt_ff[g][i] <= cnt_ff[g][(i > 0) ? i - 1 : 0];
                  bkt_ff[g][i] <= bkt_ff[g][(i > 0) ? i - 1 : 0];
               end
            end
         end
      end
   end

   // Counts, ties and statistics.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int k = 0; k < 2; k++) begin
            n_ff[k]       <= '0;
            tie_val_ff[k] <= '0;
            drop_ff[k]    <= '0;
            min_ff[k]     <= '1;
            max_ff[k]     <= '0;
            total_ff[k]   <= '0;
            buckets_ff[k] <= '0;
         end
      end else if (cmd.visit) begin
         tie_val_ff[g] <= tie_val_in;
         drop_ff[g]    <= drop_in;
         if (do_insert) begin
            n_ff[g] <= n_eff + 1'b1;
         end
         if (has_stats) begin
            if (ev < min_ff[g]) begin
               min_ff[g] <= ev;
            end
            if (ev > max_ff[g]) begin
               max_ff[g] <= ev;
            end
            total_ff[g]   <= total_ff[g] + WIDE_W'(ev);
            buckets_ff[g] <= buckets_ff[g] + 64'd1;
         end
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rtype_ff <= cmd.rtype;
         grp_ff   <= cmd.grp;
         final_ff <= cmd.final_res;
         bid_ff   <= '0;
         evc_ff   <= '0;
         tally_ff <= '0;
         sum_ff   <= '0;
         least_ff <= '0;
         most_ff  <= '0;
         case (cmd.rtype)
            REC_STATS: begin
               tally_ff <= buckets_ff[cmd.grp];
               sum_ff   <= total_ff[cmd.grp];
               least_ff <= FIELD_W'(min_ff[cmd.grp]);
               most_ff  <= FIELD_W'(max_ff[cmd.grp]);
            end
            REC_ENTRY: begin
               bid_ff <= FIELD_W'(bkt_ff[cmd.grp][rd_idx]);
               evc_ff <= FIELD_W'(cnt_ff[cmd.grp][rd_idx]);
            end
            default: begin
               evc_ff   <= FIELD_W'(tie_val_ff[cmd.grp]);
               tally_ff <= drop_ff[cmd.grp];
            end
         endcase
      end
   end

   // Group status for the controller.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         status[k].n        = CNT_W'(n_ff[k]);
         status[k].total_nz = (total_ff[k] != '0);
         status[k].drop_nz  = (drop_ff[k] != '0);
      end
   end

   assign record_type = rtype_ff;
   assign group       = grp_ff;
   assign bucket_id   = bid_ff;
   assign event_count = evc_ff;
   assign tally       = tally_ff;
   assign sum_events  = sum_ff;
   assign least       = least_ff;
   assign most        = most_ff;
   assign final_res   = final_ff;

endmodule

### design/tnb_ctrl.sv
// ----------------------------------------------------------------------------
// Top-N bucket tracker controller
// Accepts request words and sequences the flush readout and clear.
// ----------------------------------------------------------------------------
module tnb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_func,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  tnb_pkg::grp_status_type [1:0] status,
   output tnb_pkg::dp_cmd_type           cmd
);
   import tnb_pkg::*;

   ctl_state_type    state_ff, state_in;
   logic             grp_ff, grp_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [REC_W-1:0] rem_ff, rem_in;
   logic             rsp_valid_ff;

   logic             out_free;
   logic             accept;
   logic             emit_now;
   logic [REC_W-1:0] rc0, rc1;
   grp_status_type   cur;
   logic             last_entry;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign cur        = status[grp_ff];
   assign last_entry = ({1'b0, idx_ff} == (cur.n - 1'b1));
   assign rc0 = (status[0].n == '0) ? '0 :
                REC_W'(status[0].n) + REC_W'(status[0].total_nz) + REC_W'(status[0].drop_nz);
   assign rc1 = (status[1].n == '0) ? '0 :
                REC_W'(status[1].n) + REC_W'(status[1].total_nz) + REC_W'(status[1].drop_nz);

   // Next state, group, entry index and remaining word count.
   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      rem_in   = emit_now ? rem_ff - 1'b1 : rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_FLUSH)) begin
               state_in = ST_SCAN;
               grp_in   = GRP_LEAF;
               rem_in   = rc0 + rc1;
            end
         end
         ST_SCAN: begin
            idx_in = '0;
            if (cur.n == '0) begin
               if (grp_ff == GRP_BRANCH) begin
                  state_in = ST_CLEAR;
               end else begin
                  grp_in = GRP_BRANCH;
               end
            end else if (cur.total_nz) begin
               state_in = ST_STATS;
            end else begin
               state_in = ST_ENTRY;
            end
         end
         ST_STATS: begin
            if (out_free) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: begin
            if (out_free) begin
               if (!last_entry) begin
                  idx_in = idx_ff + 1'b1;
               end else if (cur.drop_nz) begin
                  state_in = ST_DROP;
               end else if (grp_ff == GRP_BRANCH) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SCAN;
                  grp_in   = GRP_BRANCH;
               end
            end
         end
         ST_DROP: begin
            if (out_free) begin
               if (grp_ff == GRP_BRANCH) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SCAN;
                  grp_in   = GRP_BRANCH;
               end
            end
         end
         ST_CLEAR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      emit_now      = 1'b0;
      cmd           = '0;
      cmd.grp       = grp_ff;
      cmd.idx       = idx_ff;
      cmd.final_res = (rem_ff == REC_W'(1));
      case (state_ff)
         ST_IDLE: begin
            cmd.visit = req_valid && (req_func == FUNC_VISIT);
         end
         ST_STATS: begin
            emit_now  = out_free;
            cmd.rtype = REC_STATS;
         end
         ST_ENTRY: begin
            emit_now  = out_free;
            cmd.rtype = REC_ENTRY;
         end
         ST_DROP: begin
            emit_now  = out_free;
            cmd.rtype = REC_DROP;
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         default: begin
            cmd.rtype = REC_STATS;
         end
      endcase
      cmd.emit = emit_now;
   end

   // Controller registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grp_ff       <= GRP_LEAF;
         idx_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         idx_ff   <= idx_in;
         rem_ff   <= rem_in;
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
